FILE: hw/rtl/fbsa_pkg.sv
// Package for the free block stack allocator.
// Holds sizes, field types, command and status codes, sequencer states.
// No dependencies.
package fbsa_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 2048;
  localparam int AW          = $clog2(MAX_BLOCKS);
  localparam int CW          = AW + 1;
  localparam int IW          = CW + 1;
  localparam int OFS_W       = 21;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  typedef logic [AW-1:0] blk_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [IW-1:0] idx_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_SORT    = 2'd2,
    CMD_REBUILD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SORT_I,
    S_SORT_V,
    S_SORT_J,
    S_SORT_C,
    S_REBUILD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic wen;
    blk_t waddr;
    blk_t wdata;
    logic ren;
    blk_t raddr;
  } mem_ctl_t;

endpackage

FILE: hw/rtl/fbsa_req_if.sv
// Request channel of the free block stack allocator.
// Depends on fbsa_pkg.
interface fbsa_req_if;
  import fbsa_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  blk_t       freed_block;
  cnt_t       range_start;
  cnt_t       range_stop;

  modport source (output valid, command, freed_block, range_start, range_stop, input ready);
  modport sink (input valid, command, freed_block, range_start, range_stop, output ready);
endinterface

FILE: hw/rtl/fbsa_rsp_if.sv
// Result channel of the free block stack allocator.
// Depends on fbsa_pkg.
interface fbsa_rsp_if;
  import fbsa_pkg::*;
  logic             valid;
  logic             ready;
  blk_t             block_number;
  logic [OFS_W-1:0] byte_offset;
  logic [1:0]       status;
  cnt_t             free_blocks;

  modport source (output valid, block_number, byte_offset, status, free_blocks, input ready);
  modport sink (input valid, block_number, byte_offset, status, free_blocks, output ready);
endinterface

FILE: hw/rtl/fbsa_mem.sv
// Free list storage: one write port, one read port with registered data.
// Depends on fbsa_pkg.
module fbsa_mem (
  input  logic               clk,
  input  fbsa_pkg::mem_ctl_t ctl,
  output fbsa_pkg::blk_t     rdata
);
  import fbsa_pkg::*;

  blk_t mem [MAX_BLOCKS];
  blk_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wen) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.ren) begin
      rdata_r <= mem[ctl.raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: hw/rtl/free_block_stack_allocator.sv
// Allocate reads the top entry of the free list (S_POP) and then registers the
// result (S_DONE); free writes the entry and then registers the result. Sort is
// an insertion sort over the given positions, with at most one memory access per
// state. Rebuild writes one entry per cycle, then registers the result.
// One request at a time. Synchronous active-low reset empties the list;
// a rebuild must be issued before the first allocate.
// Depends on fbsa_pkg, fbsa_req_if, fbsa_rsp_if, fbsa_mem.
module free_block_stack_allocator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  fbsa_pkg::cnt_t       cfg_wdata,
  fbsa_req_if.sink             in_req,
  fbsa_rsp_if.source           out_rsp
);
  import fbsa_pkg::*;

  state_t   state_r, state_nxt;
  cnt_t     pool_r;
  cnt_t     total_r, total_nxt;
  cnt_t     lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt, k_r, k_nxt;
  idx_t     i_r, i_nxt;
  blk_t     v_r, v_nxt;
  blk_t     blk_r, blk_nxt;
  status_t  st_r, st_nxt;
  logic     ovalid_r, ovalid_nxt;
  blk_t     oblk_r, oblk_nxt;
  status_t  ost_r, ost_nxt;
  cnt_t     ocnt_r, ocnt_nxt;
  mem_ctl_t ctl;
  blk_t     rdata;
  cnt_t     pool_eff;
  cnt_t     tm1;

  fbsa_mem u_mem (.clk(clk), .ctl(ctl), .rdata(rdata));

  assign pool_eff = (pool_r > cnt_t'(MAX_BLOCKS)) ? cnt_t'(MAX_BLOCKS) : pool_r;
  assign tm1      = total_r - cnt_t'(1);

  function automatic blk_t phys(input cnt_t last, input cnt_t p);
    cnt_t d;
    d = last - p;
    return d[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pool_r   <= cnt_t'(MAX_BLOCKS);
      total_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        pool_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    v_r    <= v_nxt;
    blk_r  <= blk_nxt;
    st_r   <= st_nxt;
    oblk_r <= oblk_nxt;
    ost_r  <= ost_nxt;
    ocnt_r <= ocnt_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    v_nxt      = v_r;
    blk_nxt    = blk_r;
    st_nxt     = st_r;
    ovalid_nxt = ovalid_r;
    oblk_nxt   = oblk_r;
    ost_nxt    = ost_r;
    ocnt_nxt   = ocnt_r;
    ctl        = '0;
    in_req.ready = (state_r == S_IDLE);

    if (ovalid_r && out_rsp.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          blk_nxt   = '0;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
          unique case (cmd_t'(in_req.command))
            CMD_ALLOC: begin
              if (total_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                ctl.ren   = 1'b1;
                ctl.raddr = tm1[AW-1:0];
                state_nxt = S_POP;
              end
            end
            CMD_FREE: begin
              if (total_r >= pool_eff) begin
                st_nxt = ST_FULL;
              end else begin
                ctl.wen   = 1'b1;
                ctl.waddr = total_r[AW-1:0];
                ctl.wdata = in_req.freed_block;
                total_nxt = total_r + cnt_t'(1);
              end
            end
            CMD_SORT: begin
              if (in_req.range_start > in_req.range_stop || in_req.range_stop > total_r) begin
                st_nxt = ST_RANGE;
              end else begin
                lo_nxt    = in_req.range_start;
                hi_nxt    = in_req.range_stop;
                i_nxt     = idx_t'(in_req.range_start) + idx_t'(1);
                state_nxt = S_SORT_I;
              end
            end
            CMD_REBUILD: begin
              total_nxt = pool_eff;
              k_nxt     = '0;
              state_nxt = S_REBUILD;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        blk_nxt   = rdata;
        total_nxt = tm1;
        state_nxt = S_DONE;
      end
      S_SORT_I: begin
        if (i_r >= idx_t'(hi_r)) begin
          state_nxt = S_DONE;
        end else begin
          ctl.ren   = 1'b1;
          ctl.raddr = phys(tm1, i_r[CW-1:0]);
          j_nxt     = i_r[CW-1:0];
          state_nxt = S_SORT_V;
        end
      end
      S_SORT_V: begin
        v_nxt     = rdata;
        state_nxt = S_SORT_J;
      end
      S_SORT_J: begin
        if (j_r == lo_r) begin
          ctl.wen   = 1'b1;
          ctl.waddr = phys(tm1, j_r);
          ctl.wdata = v_r;
          i_nxt     = i_r + idx_t'(1);
          state_nxt = S_SORT_I;
        end else begin
          ctl.ren   = 1'b1;
          ctl.raddr = phys(tm1, j_r - cnt_t'(1));
          state_nxt = S_SORT_C;
        end
      end
      S_SORT_C: begin
        ctl.wen   = 1'b1;
        ctl.waddr = phys(tm1, j_r);
        if (rdata > v_r) begin
          ctl.wdata = rdata;
          j_nxt     = j_r - cnt_t'(1);
          state_nxt = S_SORT_J;
        end else begin
          ctl.wdata = v_r;
          i_nxt     = i_r + idx_t'(1);
          state_nxt = S_SORT_I;
        end
      end
      S_REBUILD: begin
        if (k_r == total_r) begin
          state_nxt = S_DONE;
        end else begin
          ctl.wen   = 1'b1;
          ctl.waddr = k_r[AW-1:0];
          ctl.wdata = phys(tm1, k_r);
          k_nxt     = k_r + cnt_t'(1);
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_rsp.ready) begin
          ovalid_nxt = 1'b1;
          oblk_nxt   = blk_r;
          ost_nxt    = st_r;
          ocnt_nxt   = total_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_rsp.valid        = ovalid_r;
  assign out_rsp.block_number = oblk_r;
  assign out_rsp.byte_offset  = OFS_W'({oblk_r, BLOCK_SHIFT'(0)});
  assign out_rsp.status       = ost_r;
  assign out_rsp.free_blocks  = ocnt_r;
endmodule

FILE: tb/tb_free_block_stack_allocator.sv
// Testbench for free_block_stack_allocator: a request driver and a result
// monitor run against a behavioral predictor of the LIFO free list.
// Depends on fbsa_pkg, fbsa_req_if, fbsa_rsp_if and the allocator RTL.
module tb_free_block_stack_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import fbsa_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    cmd_t command;
    blk_t freed_block;
    cnt_t range_start;
    cnt_t range_stop;
  } request_t;

  typedef struct {
    blk_t             block_number;
    logic [OFS_W-1:0] byte_offset;
    status_t          status;
    cnt_t             free_blocks;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cnt_t cfg_wdata;

  fbsa_req_if req_ch ();
  fbsa_rsp_if rsp_ch ();

  free_block_stack_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch)
  );

  always #1 clk = ~clk;

  request_t pending_reqs[$];
  result_t  expected_results[$];

  // predictor state
  blk_t free_list[MAX_BLOCKS];
  int   free_total;
  int   pool_reg;

  // generation-side count, used to aim sort ranges
  int plan_total;
  int plan_pool;

  int  errors;
  int  accepted_reqs;
  int  checked_results;
  int  status_seen[4];
  int  idle_cycles;
  bit  req_done;
  int  burst_left;
  int  gap_left;
  int  hold_left;
  bit  long_hold_done;
  int  pattern_left;
  int  ready_mode;

  function automatic int pool_size(int p);
    return (p < MAX_BLOCKS) ? p : MAX_BLOCKS;
  endfunction

  function automatic result_t apply_request(request_t r);
    result_t res;
    int      s;
    int      e;
    blk_t    v;
    int      j;
    res.block_number = '0;
    res.status = ST_OK;
    s = int'(r.range_start);
    e = int'(r.range_stop);
    case (r.command)
      CMD_ALLOC: begin
        if (free_total == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.block_number = free_list[0];
          for (int i = 0; i < free_total - 1; i++) free_list[i] = free_list[i+1];
          free_total--;
        end
      end
      CMD_FREE: begin
        if (free_total >= pool_size(pool_reg)) begin
          res.status = ST_FULL;
        end else begin
          for (int i = free_total; i > 0; i--) free_list[i] = free_list[i-1];
          free_list[0] = r.freed_block;
          free_total++;
        end
      end
      CMD_SORT: begin
        if (s > e || e > free_total) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = s + 1; i < e; i++) begin
            v = free_list[i];
            j = i;
            while (j > s && free_list[j-1] > v) begin
              free_list[j] = free_list[j-1];
              j--;
            end
            free_list[j] = v;
          end
        end
      end
      default: begin
        free_total = pool_size(pool_reg);
        for (int i = 0; i < free_total; i++) free_list[i] = blk_t'(i);
      end
    endcase
    res.byte_offset = OFS_W'(int'(res.block_number) * BLOCK_BYTES);
    res.free_blocks = cnt_t'(free_total);
    return res;
  endfunction

  function automatic void queue_request(cmd_t c, int fb, int s, int e);
    request_t r;
    r.command = c;
    r.freed_block = blk_t'(fb);
    r.range_start = cnt_t'(s);
    r.range_stop = cnt_t'(e);
    pending_reqs.insert(pending_reqs.size(), r);
    case (c)
      CMD_ALLOC:   if (plan_total > 0) plan_total--;
      CMD_FREE:    if (plan_total < plan_pool) plan_total++;
      CMD_REBUILD: plan_total = plan_pool;
      default: ;
    endcase
  endfunction

  function automatic void queue_random_request();
    int pick;
    int s;
    int e;
    pick = $urandom_range(99);
    if (pick < 3) begin
      queue_request(CMD_REBUILD, $urandom_range(1023), $urandom_range(2047), $urandom_range(2047));
    end else if (pick < 40) begin
      queue_request(CMD_ALLOC, $urandom_range(1023), $urandom_range(2047), $urandom_range(2047));
    end else if (pick < 75) begin
      queue_request(CMD_FREE, $urandom_range(1023), $urandom_range(2047), $urandom_range(2047));
    end else if (pick < 93) begin
      s = $urandom_range(plan_total);
      e = s + $urandom_range((plan_total - s < 24) ? plan_total - s : 24);
      queue_request(CMD_SORT, $urandom_range(1023), s, e);
    end else begin
      // keep noise ranges bad so they never start a long sort
      s = $urandom_range(2047);
      e = $urandom_range(2047);
      if (s <= e && e <= plan_total) e = $urandom_range(2047, plan_total + 1);
      queue_request(CMD_SORT, $urandom_range(1023), s, e);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_pool(int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = cnt_t'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    plan_pool = pool_size(value);
  endtask

  // driver
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      req_ch.valid = 1'b0;
    end else if (req_ch.valid && !req_done) begin
    end else if (gap_left > 0) begin
      req_ch.valid = 1'b0;
      gap_left--;
    end else if (pending_reqs.size() > 0) begin
      r = pending_reqs[0];
      pending_reqs.delete(0);
      req_ch.command = r.command;
      req_ch.freed_block = r.freed_block;
      req_ch.range_start = r.range_start;
      req_ch.range_stop = r.range_stop;
      req_ch.valid = 1'b1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end else begin
      req_ch.valid = 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_ch.ready = 1'b0;
      hold_left--;
    end else if (!long_hold_done && accepted_reqs >= 300) begin
      long_hold_done = 1'b1;
      hold_left = 600;
      rsp_ch.ready = 1'b0;
    end else begin
      if (pattern_left == 0) begin
        ready_mode = $urandom_range(2);
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      case (ready_mode)
        0:       rsp_ch.ready = 1'b1;
        1:       rsp_ch.ready = $urandom_range(1);
        default: rsp_ch.ready = ($urandom_range(3) == 0);
      endcase
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    bit      req_fire;
    bit      rsp_fire;
    request_t r;
    result_t  want;
    req_fire = rst_n && req_ch.valid && req_ch.ready;
    rsp_fire = rst_n && rsp_ch.valid && rsp_ch.ready;
    req_done <= req_fire;
    if (rst_n && cfg_we) pool_reg = int'(cfg_wdata);
    if (req_fire) begin
      r.command = cmd_t'(req_ch.command);
      r.freed_block = req_ch.freed_block;
      r.range_start = req_ch.range_start;
      r.range_stop = req_ch.range_stop;
      want = apply_request(r);
      expected_results.insert(expected_results.size(), want);
      accepted_reqs++;
    end
    if (rsp_fire) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: block %0d status %0d",
               rsp_ch.block_number, rsp_ch.status);
        errors++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        checked_results++;
        status_seen[want.status]++;
        if (rsp_ch.block_number !== want.block_number) begin
          $error("block_number expected %0d got %0d", want.block_number, rsp_ch.block_number);
          errors++;
        end
        if (rsp_ch.byte_offset !== want.byte_offset) begin
          $error("byte_offset expected %0d got %0d", want.byte_offset, rsp_ch.byte_offset);
          errors++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.free_blocks !== want.free_blocks) begin
          $error("free_blocks expected %0d got %0d", want.free_blocks, rsp_ch.free_blocks);
          errors++;
        end
      end
    end
    if (req_fire || rsp_fire || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int pools[8];
    pools = '{1, 3, 16, 1024, 200, 1025, 2047, 0};
    pools[7] = $urandom_range(4, 1024);
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_ALLOC;
    req_ch.freed_block = '0;
    req_ch.range_start = '0;
    req_ch.range_stop = '0;
    rsp_ch.ready = 1'b0;
    errors = 0;
    pool_reg = 1024;
    free_total = 0;
    plan_pool = 1024;
    plan_total = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // full pool: pops, pushes, sort edge cases
    queue_request(CMD_REBUILD, 0, 0, 0);
    queue_request(CMD_ALLOC, 0, 0, 0);
    queue_request(CMD_ALLOC, 0, 0, 0);
    queue_request(CMD_FREE, 1023, 0, 0);
    queue_request(CMD_FREE, 0, 2047, 2047);
    queue_request(CMD_SORT, 0, 0, 1023);
    queue_request(CMD_SORT, 0, 5, 5);
    queue_request(CMD_SORT, 0, 1023, 1023);
    queue_request(CMD_SORT, 0, 9, 3);
    queue_request(CMD_SORT, 0, 0, 1024);
    queue_request(CMD_FREE, 512, 0, 0);
    queue_request(CMD_FREE, 7, 0, 0);
    queue_request(CMD_ALLOC, 0, 0, 0);
    wait_drained();

    // two-block pool: drain to empty, refill to full
    write_pool(2);
    queue_request(CMD_REBUILD, 0, 0, 0);
    queue_request(CMD_ALLOC, 0, 0, 0);
    queue_request(CMD_ALLOC, 0, 0, 0);
    queue_request(CMD_ALLOC, 0, 0, 0);
    queue_request(CMD_SORT, 0, 0, 0);
    queue_request(CMD_FREE, 1023, 0, 0);
    queue_request(CMD_FREE, 5, 0, 0);
    queue_request(CMD_SORT, 0, 0, 2);
    queue_request(CMD_FREE, 9, 0, 0);
    wait_drained();

    // empty pool
    write_pool(0);
    queue_request(CMD_REBUILD, 0, 0, 0);
    queue_request(CMD_ALLOC, 0, 0, 0);
    queue_request(CMD_FREE, 3, 0, 0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_pool(pools[p]);
      queue_request(CMD_REBUILD, 0, 0, 0);
      if (pools[p] >= 1024) queue_request(CMD_SORT, 0, 0, 1024);
      repeat (185) queue_random_request();
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("%0d requests, %0d results checked over pool sizes 0 to 2047",
             accepted_reqs, checked_results);
    $display("status ok %0d, empty %0d, full %0d, bad range %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fbsa_pkg.sv
hw/rtl/fbsa_req_if.sv
hw/rtl/fbsa_rsp_if.sv
hw/rtl/fbsa_mem.sv
hw/rtl/free_block_stack_allocator.sv
tb/tb_free_block_stack_allocator.sv
